/* rtl/core/damped_feedback_comb_macros.svh */
// Assertion macros shared by the checker of the damped feedback comb.
// Depends on nothing; the using scope supplies i_clk and i_rst_n.
`ifndef DAMPED_FEEDBACK_COMB_MACROS_SVH
`define DAMPED_FEEDBACK_COMB_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define DFC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DFC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/dfc_pkg.sv */
// Shared constants, types and the saturation function of the damped feedback comb.
// Depends on nothing; the interfaces, the controller, the datapath, the top level and the checker import it.
package dfc_pkg;

    // Storage and sample sizes.
    localparam int unsigned DFC_LINE_DEPTH = 4096;
    localparam int unsigned DFC_SAMPLE_W   = 16;
    localparam int unsigned DFC_ADDR_W     = $clog2(DFC_LINE_DEPTH);
    localparam int unsigned DFC_LEN_W      = DFC_ADDR_W + 1;

    // Register field widths.
    localparam int unsigned DFC_CFG_LEN_W  = 13;
    localparam int unsigned DFC_CFG_DLY_W  = 12;
    localparam int unsigned DFC_CFG_FB_W   = 16;
    localparam int unsigned DFC_CFG_DAMP_W = 15;
    localparam int unsigned DFC_CFG_DATA_W = 16;
    localparam int unsigned DFC_REG_IDX_W  = 2;
    localparam int unsigned DFC_LEN_RESET  = 4096;

    // Width in which lengths, delays and indexes are compared.
    localparam int unsigned DFC_IDX_A_W = (DFC_LEN_W > DFC_CFG_LEN_W) ? DFC_LEN_W : DFC_CFG_LEN_W;
    localparam int unsigned DFC_IDX_W   = (DFC_IDX_A_W > DFC_CFG_DLY_W) ? DFC_IDX_A_W
                                                                        : DFC_CFG_DLY_W;

    // Fixed-point coefficient arithmetic.
    localparam int unsigned DFC_COEF_SHIFT = 15;
    localparam int unsigned DFC_COEF_ONE   = 32768;
    localparam int unsigned DFC_COEF_W     = DFC_COEF_SHIFT + 1;
    localparam int unsigned DFC_DIFF_W     = DFC_SAMPLE_W + 1;
    localparam int unsigned DFC_PROD1_W    = DFC_COEF_W + 1 + DFC_DIFF_W;
    localparam int unsigned DFC_PROD2_W    = DFC_SAMPLE_W + DFC_CFG_FB_W;
    // The damping product is the wider one; one more bit holds the sums.
    localparam int unsigned DFC_WIDE_W     = DFC_PROD1_W + 1;

    // Register indexes on the configuration channel.
    typedef enum logic [DFC_REG_IDX_W-1:0] {
        REG_LINE_LENGTH,
        REG_DELAY_SAMPLES,
        REG_FEEDBACK,
        REG_DAMPING
    } t_reg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;       // word taken: capture it and start the line read
        logic damp_mult;    // read data present: form the damping product
        logic damp_update;  // settle the damping state and the wet value
        logic commit;       // write back, advance index, load the result
        logic bypass;       // current word passes straight through
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic len_zero;     // line length register is zero
    } t_dp_sts;

    // Clamp a wide signed value to the sample range.
    function automatic logic signed [DFC_SAMPLE_W-1:0] dfc_sat(
        input logic signed [DFC_WIDE_W-1:0] v
    );
        logic signed [DFC_WIDE_W-1:0] hi;
        logic signed [DFC_WIDE_W-1:0] lo;
        hi = {{(DFC_WIDE_W-DFC_SAMPLE_W+1){1'b0}}, {(DFC_SAMPLE_W-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return hi[DFC_SAMPLE_W-1:0];
        end else if (v < lo) begin
            return lo[DFC_SAMPLE_W-1:0];
        end
        return v[DFC_SAMPLE_W-1:0];
    endfunction

endpackage

/* rtl/core/dfc_interfaces.sv */
// Channel interfaces of the damped feedback comb: sample in, sample out, register writes.
// Depends on dfc_pkg.

// Input sample channel.
interface dfc_in_if;
    import dfc_pkg::*;
    logic                           valid;
    logic                           ready;
    logic signed [DFC_SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// Output sample channel.
interface dfc_out_if;
    import dfc_pkg::*;
    logic                           valid;
    logic                           ready;
    logic signed [DFC_SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// Register write channel.
interface dfc_cfg_if;
    import dfc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [DFC_REG_IDX_W-1:0]  index;
    logic [DFC_CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/damped_feedback_comb.sv */
// Damped feedback comb: an input word that is taken passes through the line read, the damping
// multiply, the state update and the write-back, where its result word is loaded; the next input
// word is taken only after that write-back, and a zero line length goes straight to write-back.
// A waiting result does not block the next input word; only the write-back waits for it.
// Reset is synchronous; inputs are taken from the cycle after it ends, with no line sweep,
// as a fill mark reads entries not written since the last clear as zero.
module damped_feedback_comb (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dfc_in_if.sink    i_sample,
    dfc_out_if.source o_sample,
    dfc_cfg_if.sink   i_cfg
);
    import dfc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;
    logic    out_valid;
    logic    cfg_ready;
    logic signed [DFC_SAMPLE_W-1:0] sample_out;

    // Sequencing and handshakes.
    dfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_sample.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Registers, delay line and arithmetic.
    dfc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_sample_in  (i_sample.sample_in),
        .o_sample_out (sample_out),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .o_cfg_ready  (cfg_ready)
    );

    assign i_sample.ready      = in_ready;
    assign o_sample.valid      = out_valid;
    assign o_sample.sample_out = sample_out;
    assign i_cfg.ready         = cfg_ready;
endmodule

/* rtl/core/dfc_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module dfc_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

/* rtl/core/dfc_ctrl.sv */
// Sequencing controller of the damped feedback comb: handshakes and datapath commands.
// Depends on dfc_pkg.
module dfc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  dfc_pkg::t_dp_sts  i_sts,
    output dfc_pkg::t_dp_cmd  o_cmd
);
    import dfc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_MIX,
        ST_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   n_in_ready;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   r_bypass;
    logic   n_bypass;
    logic   in_acc;
    logic   out_free;

    assign in_acc   = i_in_valid && r_in_ready;
    // The result register can take a new word when empty or being emptied.
    assign out_free = !r_out_valid || i_out_ready;

    // Next-state and registered-output logic.
    always_comb begin
        n_state     = r_state;
        n_in_ready  = r_in_ready;
        n_bypass    = r_bypass;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                n_in_ready = 1'b1;
                if (in_acc) begin
                    n_in_ready = 1'b0;
                    n_bypass   = i_sts.len_zero;
                    n_state    = i_sts.len_zero ? ST_COMMIT : ST_MULT;
                end
            end
            ST_MULT: begin
                n_state = ST_MIX;
            end
            ST_MIX: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_in_ready  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state    = ST_IDLE;
                n_in_ready = 1'b0;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
            r_bypass    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
            r_bypass    <= n_bypass;
        end
    end

    // Commands decoded from the current state.
    always_comb begin
        o_cmd             = '0;
        o_cmd.accept      = in_acc;
        o_cmd.damp_mult   = (r_state == ST_MULT);
        o_cmd.damp_update = (r_state == ST_MIX);
        o_cmd.commit      = (r_state == ST_COMMIT) && out_free;
        o_cmd.bypass      = r_bypass;
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;
endmodule

/* rtl/core/dfc_dp.sv */
// Datapath of the damped feedback comb: registers, delay line, damping and feedback.
// Depends on dfc_pkg and dfc_ram.
module dfc_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  dfc_pkg::t_dp_cmd                        i_cmd,
    output dfc_pkg::t_dp_sts                        o_sts,
    input  logic signed [dfc_pkg::DFC_SAMPLE_W-1:0] i_sample_in,
    output logic signed [dfc_pkg::DFC_SAMPLE_W-1:0] o_sample_out,
    input  logic                                    i_cfg_valid,
    input  logic [dfc_pkg::DFC_REG_IDX_W-1:0]       i_cfg_index,
    input  logic [dfc_pkg::DFC_CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                    o_cfg_ready
);
    import dfc_pkg::*;

    // Configuration registers.
    logic [DFC_CFG_LEN_W-1:0]         r_line_length;
    logic [DFC_CFG_DLY_W-1:0]         r_delay;
    logic signed [DFC_CFG_FB_W-1:0]   r_feedback;
    logic [DFC_CFG_DAMP_W-1:0]        r_damping;
    logic                             r_cfg_ready;

    // Line position and damping state.
    logic [DFC_ADDR_W-1:0]            r_wr_idx;
    logic                             r_filled;
    logic signed [DFC_SAMPLE_W-1:0]   r_damp;

    // Per-word working registers.
    logic signed [DFC_SAMPLE_W-1:0]   r_x;
    logic                             r_rd_valid;
    logic signed [DFC_SAMPLE_W-1:0]   r_wet_raw;
    logic signed [DFC_PROD1_W-1:0]    r_prod1;
    logic signed [DFC_SAMPLE_W-1:0]   r_wet;
    logic signed [DFC_SAMPLE_W-1:0]   r_out_data;

    logic                             cfg_acc;
    logic [DFC_IDX_W-1:0]             len_eff;
    logic [DFC_IDX_W-1:0]             len_lim;
    logic [DFC_IDX_W-1:0]             dly_ext;
    logic [DFC_IDX_W-1:0]             dly_eff;
    logic [DFC_IDX_W-1:0]             wi_ext;
    logic [DFC_IDX_W-1:0]             wi_inc;
    logic                             wi_wrap;
    logic [DFC_IDX_W-1:0]             rd_pos;
    logic                             rd_valid;
    logic [DFC_SAMPLE_W-1:0]          rd_data;
    logic signed [DFC_SAMPLE_W-1:0]   wet_raw;
    logic [DFC_COEF_W-1:0]            coef;
    logic signed [DFC_COEF_W:0]       coef_s;
    logic signed [DFC_DIFF_W-1:0]     diff;
    logic signed [DFC_PROD1_W-1:0]    prod1;
    logic signed [DFC_WIDE_W-1:0]     damp_sum;
    logic signed [DFC_SAMPLE_W-1:0]   damp_next;
    logic signed [DFC_PROD2_W-1:0]    prod2;
    logic signed [DFC_WIDE_W-1:0]     fb_sum;
    logic signed [DFC_SAMPLE_W-1:0]   wr_word;
    logic                             wr_en;

    assign cfg_acc     = i_cfg_valid && r_cfg_ready;
    assign o_cfg_ready = r_cfg_ready;
    assign o_sts.len_zero = (r_line_length == '0);

    // Effective length, clamped delay and the read position behind the write index.
    always_comb begin
        if (DFC_IDX_W'(r_line_length) > DFC_IDX_W'(DFC_LINE_DEPTH)) begin
            len_eff = DFC_IDX_W'(DFC_LINE_DEPTH);
        end else begin
            len_eff = DFC_IDX_W'(r_line_length);
        end
        len_lim = len_eff - 1'b1;
        dly_ext = DFC_IDX_W'(r_delay);
        dly_eff = (dly_ext > len_lim) ? len_lim : dly_ext;
        wi_ext  = DFC_IDX_W'(r_wr_idx);
        if (wi_ext >= dly_eff) begin
            rd_pos = wi_ext - dly_eff;
        end else begin
            rd_pos = wi_ext + len_eff - dly_eff;
        end
        // Entries at or beyond the write index hold nothing since the last clear
        // until the index has wrapped once; they read as zero.
        rd_valid = r_filled || (rd_pos < wi_ext);
        wi_inc   = wi_ext + 1'b1;
        wi_wrap  = (wi_inc >= len_eff);
    end

    // Damping product: (one minus damping) times (wet minus state).
    always_comb begin
        wet_raw = r_rd_valid ? $signed(rd_data) : '0;
        coef    = DFC_COEF_W'(DFC_COEF_ONE) - DFC_COEF_W'(r_damping);
        coef_s  = $signed({1'b0, coef});
        diff    = DFC_DIFF_W'(wet_raw) - DFC_DIFF_W'(r_damp);
        prod1   = DFC_PROD1_W'(coef_s) * DFC_PROD1_W'(diff);
    end

    // State update from the registered product, floor-shifted.
    always_comb begin
        damp_sum  = DFC_WIDE_W'(r_damp) + DFC_WIDE_W'(r_prod1 >>> DFC_COEF_SHIFT);
        damp_next = dfc_sat(damp_sum);
    end

    // Feedback word: input plus wet times gain, saturated.
    always_comb begin
        prod2   = DFC_PROD2_W'(r_wet) * DFC_PROD2_W'(r_feedback);
        fb_sum  = DFC_WIDE_W'(r_x) + DFC_WIDE_W'(prod2 >>> DFC_COEF_SHIFT);
        wr_word = dfc_sat(fb_sum);
        wr_en   = i_cmd.commit && !i_cmd.bypass;
    end

    // Delay line storage.
    dfc_ram #(
        .WIDTH (DFC_SAMPLE_W),
        .DEPTH (DFC_LINE_DEPTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wr_idx),
        .i_wr_data (wr_word),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (rd_pos[DFC_ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Configuration registers, line position and damping state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= DFC_CFG_LEN_W'(DFC_LEN_RESET);
            r_delay       <= '0;
            r_feedback    <= '0;
            r_damping     <= '0;
            r_cfg_ready   <= 1'b0;
            r_wr_idx      <= '0;
            r_filled      <= 1'b0;
            r_damp        <= '0;
        end else begin
            r_cfg_ready <= 1'b1;
            if (cfg_acc) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_LINE_LENGTH: begin
                        // A new length empties the line and restarts the index.
                        r_line_length <= i_cfg_data[DFC_CFG_LEN_W-1:0];
                        r_wr_idx      <= '0;
                        r_filled      <= 1'b0;
                    end
                    REG_DELAY_SAMPLES: begin
                        r_delay <= i_cfg_data[DFC_CFG_DLY_W-1:0];
                    end
                    REG_FEEDBACK: begin
                        r_feedback <= $signed(i_cfg_data[DFC_CFG_FB_W-1:0]);
                    end
                    REG_DAMPING: begin
                        r_damping <= i_cfg_data[DFC_CFG_DAMP_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.damp_update && (r_damping != '0)) begin
                r_damp <= damp_next;
            end
            if (wr_en) begin
                if (wi_wrap) begin
                    r_wr_idx <= '0;
                    r_filled <= 1'b1;
                end else begin
                    r_wr_idx <= wi_inc[DFC_ADDR_W-1:0];
                end
            end
        end
    end

    // Per-word pipeline registers and the result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x        <= i_sample_in;
            r_rd_valid <= rd_valid;
        end
        if (i_cmd.damp_mult) begin
            r_wet_raw <= wet_raw;
            r_prod1   <= prod1;
        end
        if (i_cmd.damp_update) begin
            r_wet <= (r_damping != '0) ? damp_next : r_wet_raw;
        end
        if (i_cmd.commit) begin
            r_out_data <= i_cmd.bypass ? r_x : r_wet;
        end
    end

    assign o_sample_out = r_out_data;
endmodule

/* rtl/core/dfc_checker.sv */
// Port-level checks of the damped feedback comb, bound to the top level.
// Depends on dfc_pkg and damped_feedback_comb_macros.svh.
`include "damped_feedback_comb_macros.svh"

module dfc_checker (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    i_in_valid,
    input logic                                    i_in_ready,
    input logic                                    i_out_valid,
    input logic                                    i_out_ready,
    input logic signed [dfc_pkg::DFC_SAMPLE_W-1:0] i_out_data
);
    import dfc_pkg::*;

    // A stalled result word stays offered and unchanged.
    `DFC_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "result word changed while stalled")

    // One word is worked at a time: input closes right after a word is taken.
    `DFC_ASSERT_NXT(a_one_word, i_in_valid && i_in_ready, !i_in_ready, "input still open after a word was taken")

    // A new result only appears after a busy cycle in which no input was taken.
    `DFC_ASSERT_IMP(a_result_after_work, $rose(i_out_valid), !$past(i_in_ready), "result appeared without work")
endmodule

bind damped_feedback_comb dfc_checker u_dfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_sample.valid),
    .i_out_ready (o_sample.ready),
    .i_out_data  (o_sample.sample_out)
);
